// File: rtl/core/hrhp_pkg.sv
package hrhp_pkg;

  localparam int unsigned StateW = 5;

  localparam logic [StateW-1:0] StMethodStart = 5'd0;
  localparam logic [StateW-1:0] StMethod      = 5'd1;
  localparam logic [StateW-1:0] StUri         = 5'd2;
  localparam logic [StateW-1:0] StVerH        = 5'd3;
  localparam logic [StateW-1:0] StVerT1       = 5'd4;
  localparam logic [StateW-1:0] StVerT2       = 5'd5;
  localparam logic [StateW-1:0] StVerP        = 5'd6;
  localparam logic [StateW-1:0] StVerSlash    = 5'd7;
  localparam logic [StateW-1:0] StMajorStart  = 5'd8;
  localparam logic [StateW-1:0] StMajor       = 5'd9;
  localparam logic [StateW-1:0] StMinorStart  = 5'd10;
  localparam logic [StateW-1:0] StMinor       = 5'd11;
  localparam logic [StateW-1:0] StNl1         = 5'd12;
  localparam logic [StateW-1:0] StLineStart   = 5'd13;
  localparam logic [StateW-1:0] StLws         = 5'd14;
  localparam logic [StateW-1:0] StHname       = 5'd15;
  localparam logic [StateW-1:0] StSpaceBefore = 5'd16;
  localparam logic [StateW-1:0] StHvalue      = 5'd17;
  localparam logic [StateW-1:0] StNl2         = 5'd18;
  localparam logic [StateW-1:0] StNl3         = 5'd19;

  typedef enum logic [2:0] {
    TAG_NONE   = 3'd0,
    TAG_METHOD = 3'd1,
    TAG_URI    = 3'd2,
    TAG_HNAME  = 3'd3,
    TAG_HVALUE = 3'd4
  } field_tag_e;

  typedef enum logic [1:0] {
    STAT_PENDING = 2'd0,
    STAT_GOOD    = 2'd1,
    STAT_BAD     = 2'd2
  } status_e;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_RESTART = 1'b1
  } kind_e;

  localparam logic [7:0] ChSp      = 8'h20;
  localparam logic [7:0] ChHt      = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0d;
  localparam logic [7:0] ChLf      = 8'h0a;
  localparam logic [7:0] ChSlash   = 8'h2f;
  localparam logic [7:0] ChDot     = 8'h2e;
  localparam logic [7:0] ChColon   = 8'h3a;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2b;
  localparam logic [7:0] ChDel     = 8'h7f;
  localparam logic [7:0] CtlMax    = 8'h1f;

  typedef struct packed {
    logic path_ok;
    logic dir;
  } uri_stat_t;

  typedef struct packed {
    status_e    status;
    field_tag_e tag;
    logic       new_header;
    logic       dir;
  } result_t;

  function automatic logic ctl_byte(input logic [7:0] c);
    return (c <= CtlMax) || (c == ChDel);
  endfunction

  function automatic logic special_byte(input logic [7:0] c);
    logic r;
    unique case (c)
      8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
      8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, 8'h20, 8'h09: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic token_byte(input logic [7:0] c);
    return !c[7] && !ctl_byte(c) && !special_byte(c);
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) r = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) r = 5'(c - 8'h37);
    return r;
  endfunction

endpackage

// File: rtl/core/hrhp_uri_dec.sv
module hrhp_uri_dec (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 restart_i,
  input  logic                 byte_en_i,
  input  logic [7:0]           byte_i,
  output hrhp_pkg::uri_stat_t  stat_o
);

  logic [1:0] phase_q, phase_d;
  logic [3:0] hi_q, hi_d;
  logic       nonempty_q, nonempty_d;
  logic       first_slash_q, first_slash_d;
  logic       prev_dot_q, prev_dot_d;
  logic       dotdot_q, dotdot_d;
  logic       failed_q, failed_d;
  logic       last_slash_q, last_slash_d;

  logic [4:0] hex;
  logic [7:0] dec;
  logic       emit;

  always_comb begin
    phase_d       = phase_q;
    hi_d          = hi_q;
    nonempty_d    = nonempty_q;
    first_slash_d = first_slash_q;
    prev_dot_d    = prev_dot_q;
    dotdot_d      = dotdot_q;
    failed_d      = failed_q;
    last_slash_d  = last_slash_q;
    hex           = hrhp_pkg::hex_value(byte_i);
    dec           = byte_i;
    emit          = 1'b0;

    if (phase_q == 2'd0) begin
      if (byte_i == hrhp_pkg::ChPercent) begin
        phase_d = 2'd1;
      end else begin
        emit = 1'b1;
        dec  = (byte_i == hrhp_pkg::ChPlus) ? hrhp_pkg::ChSp : byte_i;
      end
    end else if (hex[4]) begin
      failed_d = 1'b1;
      phase_d  = 2'd0;
    end else if (phase_q == 2'd1) begin
      hi_d    = hex[3:0];
      phase_d = 2'd2;
    end else begin
      emit    = 1'b1;
      dec     = {hi_q, hex[3:0]};
      phase_d = 2'd0;
    end

    if (emit) begin
      if (!nonempty_q) begin
        first_slash_d = (dec == hrhp_pkg::ChSlash);
        nonempty_d    = 1'b1;
      end
      if (dec == hrhp_pkg::ChDot && prev_dot_q) dotdot_d = 1'b1;
      prev_dot_d   = (dec == hrhp_pkg::ChDot);
      last_slash_d = (dec == hrhp_pkg::ChSlash);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= 2'd0;
      hi_q          <= 4'd0;
      nonempty_q    <= 1'b0;
      first_slash_q <= 1'b0;
      prev_dot_q    <= 1'b0;
      dotdot_q      <= 1'b0;
      failed_q      <= 1'b0;
      last_slash_q  <= 1'b0;
    end else if (restart_i) begin
      phase_q       <= 2'd0;
      hi_q          <= 4'd0;
      nonempty_q    <= 1'b0;
      first_slash_q <= 1'b0;
      prev_dot_q    <= 1'b0;
      dotdot_q      <= 1'b0;
      failed_q      <= 1'b0;
      last_slash_q  <= 1'b0;
    end else if (byte_en_i) begin
      phase_q       <= phase_d;
      hi_q          <= hi_d;
      nonempty_q    <= nonempty_d;
      first_slash_q <= first_slash_d;
      prev_dot_q    <= prev_dot_d;
      dotdot_q      <= dotdot_d;
      failed_q      <= failed_d;
      last_slash_q  <= last_slash_d;
    end
  end

  assign stat_o.path_ok = !failed_q && (phase_q == 2'd0) && nonempty_q &&
                          first_slash_q && !dotdot_q;
  assign stat_o.dir     = last_slash_q;

endmodule

// File: rtl/core/hrhp_parser.sv
module hrhp_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 restart_i,
  input  logic [7:0]           byte_i,
  input  hrhp_pkg::uri_stat_t  uri_i,
  output logic                 uri_en_o,
  output hrhp_pkg::result_t    res_o
);

  logic [hrhp_pkg::StateW-1:0] state_q, state_d;
  logic                        have_hdr_q, have_hdr_d;
  logic                        bad, good, uri_byte;
  hrhp_pkg::field_tag_e        tag;
  logic                        newh;
  logic                        ctl, tok, dig, sp, ws, cr, lf;

  always_comb begin
    ctl        = hrhp_pkg::ctl_byte(byte_i);
    tok        = hrhp_pkg::token_byte(byte_i);
    dig        = hrhp_pkg::digit_byte(byte_i);
    sp         = (byte_i == hrhp_pkg::ChSp);
    ws         = sp || (byte_i == hrhp_pkg::ChHt);
    cr         = (byte_i == hrhp_pkg::ChCr);
    lf         = (byte_i == hrhp_pkg::ChLf);
    state_d    = state_q;
    have_hdr_d = have_hdr_q;
    bad        = 1'b0;
    good       = 1'b0;
    uri_byte   = 1'b0;
    tag        = hrhp_pkg::TAG_NONE;
    newh       = 1'b0;

    unique case (state_q)
      hrhp_pkg::StMethodStart: begin
        if (tok) begin
          state_d = hrhp_pkg::StMethod;
          tag     = hrhp_pkg::TAG_METHOD;
        end else bad = 1'b1;
      end
      hrhp_pkg::StMethod: begin
        if (sp) state_d = hrhp_pkg::StUri;
        else if (tok) tag = hrhp_pkg::TAG_METHOD;
        else bad = 1'b1;
      end
      hrhp_pkg::StUri: begin
        if (sp) state_d = hrhp_pkg::StVerH;
        else if (ctl) bad = 1'b1;
        else begin
          tag      = hrhp_pkg::TAG_URI;
          uri_byte = 1'b1;
        end
      end
      hrhp_pkg::StVerH: begin
        if (byte_i == 8'h48) state_d = hrhp_pkg::StVerT1; else bad = 1'b1;
      end
      hrhp_pkg::StVerT1: begin
        if (byte_i == 8'h54) state_d = hrhp_pkg::StVerT2; else bad = 1'b1;
      end
      hrhp_pkg::StVerT2: begin
        if (byte_i == 8'h54) state_d = hrhp_pkg::StVerP; else bad = 1'b1;
      end
      hrhp_pkg::StVerP: begin
        if (byte_i == 8'h50) state_d = hrhp_pkg::StVerSlash; else bad = 1'b1;
      end
      hrhp_pkg::StVerSlash: begin
        if (byte_i == hrhp_pkg::ChSlash) state_d = hrhp_pkg::StMajorStart;
        else bad = 1'b1;
      end
      hrhp_pkg::StMajorStart: begin
        if (dig) state_d = hrhp_pkg::StMajor; else bad = 1'b1;
      end
      hrhp_pkg::StMajor: begin
        if (byte_i == hrhp_pkg::ChDot) state_d = hrhp_pkg::StMinorStart;
        else if (!dig) bad = 1'b1;
      end
      hrhp_pkg::StMinorStart: begin
        if (dig) state_d = hrhp_pkg::StMinor; else bad = 1'b1;
      end
      hrhp_pkg::StMinor: begin
        if (cr) state_d = hrhp_pkg::StNl1;
        else if (!dig) bad = 1'b1;
      end
      hrhp_pkg::StNl1: begin
        if (lf) state_d = hrhp_pkg::StLineStart; else bad = 1'b1;
      end
      hrhp_pkg::StLineStart: begin
        if (cr) state_d = hrhp_pkg::StNl3;
        else if (have_hdr_q && ws) state_d = hrhp_pkg::StLws;
        else if (tok) begin
          have_hdr_d = 1'b1;
          state_d    = hrhp_pkg::StHname;
          tag        = hrhp_pkg::TAG_HNAME;
          newh       = 1'b1;
        end else bad = 1'b1;
      end
      hrhp_pkg::StLws: begin
        if (cr) state_d = hrhp_pkg::StNl2;
        else if (ws) state_d = hrhp_pkg::StLws;
        else if (ctl) bad = 1'b1;
        else begin
          state_d = hrhp_pkg::StHvalue;
          tag     = hrhp_pkg::TAG_HVALUE;
        end
      end
      hrhp_pkg::StHname: begin
        if (byte_i == hrhp_pkg::ChColon) state_d = hrhp_pkg::StSpaceBefore;
        else if (tok) tag = hrhp_pkg::TAG_HNAME;
        else bad = 1'b1;
      end
      hrhp_pkg::StSpaceBefore: begin
        if (sp) state_d = hrhp_pkg::StHvalue; else bad = 1'b1;
      end
      hrhp_pkg::StHvalue: begin
        if (cr) state_d = hrhp_pkg::StNl2;
        else if (ctl) bad = 1'b1;
        else tag = hrhp_pkg::TAG_HVALUE;
      end
      hrhp_pkg::StNl2: begin
        if (lf) state_d = hrhp_pkg::StLineStart; else bad = 1'b1;
      end
      hrhp_pkg::StNl3: begin
        if (lf && uri_i.path_ok) good = 1'b1;
        else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase

    if (bad) begin
      res_o.status     = hrhp_pkg::STAT_BAD;
      res_o.tag        = hrhp_pkg::TAG_NONE;
      res_o.new_header = 1'b0;
      res_o.dir        = 1'b0;
    end else begin
      res_o.status     = good ? hrhp_pkg::STAT_GOOD : hrhp_pkg::STAT_PENDING;
      res_o.tag        = tag;
      res_o.new_header = newh;
      res_o.dir        = good && uri_i.dir;
    end
  end

  assign uri_en_o = accept_i && !restart_i && uri_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= hrhp_pkg::StMethodStart;
      have_hdr_q <= 1'b0;
    end else if (accept_i) begin
      if (restart_i) begin
        state_q    <= hrhp_pkg::StMethodStart;
        have_hdr_q <= 1'b0;
      end else if (!bad) begin
        state_q    <= state_d;
        have_hdr_q <= have_hdr_d;
      end
    end
  end

endmodule

// File: rtl/core/http_request_header_parser.sv
// Each result is registered and held on the master side until it is taken.
// Throughput: 1 byte per cycle while m_axis_tready is high; the parser state and
// the URI decoder update in the same cycle the byte is taken.
// Reset: asynchronous, active low; parser at method start, decoder cleared,
// no result pending.
module http_request_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [1:0] status, [2] new_header,
                                      // [10:3] data_out, [11] path_is_directory
  output logic [2:0]  m_axis_tuser    // [2:0] field_tag
);

  logic                accept;
  logic                restart;
  logic                uri_en;
  hrhp_pkg::uri_stat_t uri_stat;
  hrhp_pkg::result_t   res;

  logic                out_valid_q;
  hrhp_pkg::result_t   res_q, res_d;
  logic [7:0]          data_q, data_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign restart       = (s_axis_tuser == hrhp_pkg::KIND_RESTART);

  hrhp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .restart_i (restart),
    .byte_i    (s_axis_tdata),
    .uri_i     (uri_stat),
    .uri_en_o  (uri_en),
    .res_o     (res)
  );

  hrhp_uri_dec u_uri_dec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (accept && restart),
    .byte_en_i (uri_en),
    .byte_i    (s_axis_tdata),
    .stat_o    (uri_stat)
  );

  always_comb begin
    if (restart) begin
      res_d.status     = hrhp_pkg::STAT_PENDING;
      res_d.tag        = hrhp_pkg::TAG_NONE;
      res_d.new_header = 1'b0;
      res_d.dir        = 1'b0;
      data_d           = 8'd0;
    end else begin
      res_d  = res;
      data_d = s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q  <= res_d;
      data_q <= data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, res_q.dir, data_q, res_q.new_header, res_q.status};
  assign m_axis_tuser  = res_q.tag;

`ifndef ASSERT_OFF
  a_dir_only_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.status != hrhp_pkg::STAT_GOOD |-> !res_q.dir)
    else $error("directory flag without good status");

  a_bad_untagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.status == hrhp_pkg::STAT_BAD |->
      res_q.tag == hrhp_pkg::TAG_NONE && !res_q.new_header)
    else $error("bad byte carries a tag");

  a_newh_is_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.new_header |-> res_q.tag == hrhp_pkg::TAG_HNAME)
    else $error("header start outside header name");

  a_restart_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && restart |=> m_axis_tvalid && m_axis_tdata == 16'd0 &&
      m_axis_tuser == hrhp_pkg::TAG_NONE)
    else $error("restart result not cleared");
`endif

endmodule
